// ----- src/mmb_pkg.sv -----
// shared types, constants and arithmetic helpers of the model matrix builder
package mmb_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MUL_W       = VALUE_WIDTH + 1;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int RED_W       = 34;
  localparam int Q30_W       = 31;
  localparam int CONV_SH     = 30 - FRAC_BITS;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam val_t ONE_Q   = val_t'(64'd1 << FRAC_BITS);

  localparam logic [RED_W-1:0] FULL_DEG    = RED_W'(64'd360 << FRAC_BITS);
  localparam logic [RED_W-1:0] QUARTER_DEG = RED_W'(64'd90 << FRAC_BITS);
  localparam logic [RED_W-1:0] ANGLE_BIAS  = RED_W'(64'd92 * (64'd360 << FRAC_BITS));
  localparam logic [MUL_W-1:0] DEG2RAD     = MUL_W'(64'd74961321);
  localparam logic [Q30_W-1:0] Q30_ONE     = Q30_W'(64'd1 << 30);
  localparam logic [Q30_W-1:0] Q30_HALF_LSB = Q30_W'(64'd1 << (CONV_SH - 1));

  // command codes of the input item
  typedef enum logic [2:0] {
    CMD_SET_POS = 3'd0,
    CMD_SET_ROT = 3'd1,
    CMD_SET_SCL = 3'd2,
    CMD_ADD_ROT = 3'd3,
    CMD_ADD_POS = 3'd4,
    CMD_MUL_SCL = 3'd5,
    CMD_UNIFORM = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {OP_NONE, OP_SET, OP_ADD, OP_MUL} op_e;
  typedef enum logic [1:0] {TGT_POS, TGT_ROT, TGT_SCL} tgt_e;

  typedef struct packed {
    logic [2:0] command;
    val_t       vec_x;
    val_t       vec_y;
    val_t       vec_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0] row_index;
    val_t       col0;
    val_t       col1;
    val_t       col2;
    val_t       col3;
    logic       last_row;
  } out_item_t;

  // classified command as it travels from front to back
  typedef struct packed {
    op_e  op;
    tgt_e tgt;
    val_t v0;
    val_t v1;
    val_t v2;
  } work_t;

  // matrix sequencer operations
  typedef enum logic [3:0] {
    S_SX, S_CX, S_SY, S_CY, S_SZ, S_CZ, S_SXSY, S_CXSY,
    S_ACC, S_C0, S_C1, S_C2, S_SC0, S_SC1, S_SC2, S_ONE
  } src_e;
  typedef enum logic [2:0] {D_SXSY, D_CXSY, D_ACC, D_C0, D_C1, D_C2} dst_e;
  typedef enum logic [1:0] {M_SET, M_NEG, M_ADD, M_SUB} mode_e;
  typedef enum logic {K_MUL, K_EMIT} kind_e;

  typedef struct packed {
    kind_e      kind;
    src_e       a;
    src_e       b;
    dst_e       dst;
    mode_e      mode;
    logic [1:0] row;
  } mop_t;

  localparam logic [4:0] MAT_LAST = 5'd27;

  function automatic mop_t mk(input kind_e k, input src_e a, input src_e b,
                              input dst_e d, input mode_e m, input logic [1:0] r);
    mop_t o;
    o.kind = k; o.a = a; o.b = b; o.dst = d; o.mode = m; o.row = r;
    return o;
  endfunction

  // program for the rotation products, per-axis scaling and row transfers
  function automatic mop_t mat_op(input logic [4:0] k);
    case (k)
      5'd0:  return mk(K_MUL, S_SX, S_SY, D_SXSY, M_SET, 2'd0);
      5'd1:  return mk(K_MUL, S_CX, S_SY, D_CXSY, M_SET, 2'd0);
      5'd2:  return mk(K_MUL, S_CY, S_CZ, D_C0, M_SET, 2'd0);
      5'd3:  return mk(K_MUL, S_CY, S_SZ, D_C1, M_NEG, 2'd0);
      5'd4:  return mk(K_MUL, S_SY, S_ONE, D_C2, M_SET, 2'd0);
      5'd5:  return mk(K_MUL, S_C0, S_SC0, D_C0, M_SET, 2'd0);
      5'd6:  return mk(K_MUL, S_C1, S_SC1, D_C1, M_SET, 2'd0);
      5'd7:  return mk(K_MUL, S_C2, S_SC2, D_C2, M_SET, 2'd0);
      5'd8:  return mk(K_EMIT, S_ONE, S_ONE, D_ACC, M_SET, 2'd0);
      5'd9:  return mk(K_MUL, S_SXSY, S_CZ, D_ACC, M_SET, 2'd1);
      5'd10: return mk(K_MUL, S_CX, S_SZ, D_C0, M_ADD, 2'd1);
      5'd11: return mk(K_MUL, S_CX, S_CZ, D_ACC, M_SET, 2'd1);
      5'd12: return mk(K_MUL, S_SXSY, S_SZ, D_C1, M_SUB, 2'd1);
      5'd13: return mk(K_MUL, S_SX, S_CY, D_C2, M_NEG, 2'd1);
      5'd14: return mk(K_MUL, S_C0, S_SC0, D_C0, M_SET, 2'd1);
      5'd15: return mk(K_MUL, S_C1, S_SC1, D_C1, M_SET, 2'd1);
      5'd16: return mk(K_MUL, S_C2, S_SC2, D_C2, M_SET, 2'd1);
      5'd17: return mk(K_EMIT, S_ONE, S_ONE, D_ACC, M_SET, 2'd1);
      5'd18: return mk(K_MUL, S_SX, S_SZ, D_ACC, M_SET, 2'd2);
      5'd19: return mk(K_MUL, S_CXSY, S_CZ, D_C0, M_SUB, 2'd2);
      5'd20: return mk(K_MUL, S_CXSY, S_SZ, D_ACC, M_SET, 2'd2);
      5'd21: return mk(K_MUL, S_SX, S_CZ, D_C1, M_ADD, 2'd2);
      5'd22: return mk(K_MUL, S_CX, S_CY, D_C2, M_SET, 2'd2);
      5'd23: return mk(K_MUL, S_C0, S_SC0, D_C0, M_SET, 2'd2);
      5'd24: return mk(K_MUL, S_C1, S_SC1, D_C1, M_SET, 2'd2);
      5'd25: return mk(K_MUL, S_C2, S_SC2, D_C2, M_SET, 2'd2);
      5'd26: return mk(K_EMIT, S_ONE, S_ONE, D_ACC, M_SET, 2'd2);
      default: return mk(K_EMIT, S_ONE, S_ONE, D_ACC, M_SET, 2'd3);
    endcase
  endfunction

  // subtrahends of the angle reduction: 360 deg steps, then two quadrant steps
  function automatic logic [RED_W-1:0] red_const(input logic [3:0] k);
    case (k)
      4'd0:    return FULL_DEG << 7;
      4'd1:    return FULL_DEG << 6;
      4'd2:    return FULL_DEG << 5;
      4'd3:    return FULL_DEG << 4;
      4'd4:    return FULL_DEG << 3;
      4'd5:    return FULL_DEG << 2;
      4'd6:    return FULL_DEG << 1;
      4'd7:    return FULL_DEG;
      4'd8:    return QUARTER_DEG << 1;
      default: return QUARTER_DEG;
    endcase
  endfunction

  // series divisors: sine chain then cosine chain
  function automatic logic [5:0] div_den(input logic [2:0] k);
    case (k)
      3'd0:    return 6'd42;
      3'd1:    return 6'd20;
      3'd2:    return 6'd6;
      3'd3:    return 6'd56;
      3'd4:    return 6'd30;
      3'd5:    return 6'd12;
      default: return 6'd2;
    endcase
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] div_recip(input logic [2:0] k);
    case (k)
      3'd0:    return 32'((64'd1 << 32) / 64'd42);
      3'd1:    return 32'((64'd1 << 32) / 64'd20);
      3'd2:    return 32'((64'd1 << 32) / 64'd6);
      3'd3:    return 32'((64'd1 << 32) / 64'd56);
      3'd4:    return 32'((64'd1 << 32) / 64'd30);
      3'd5:    return 32'((64'd1 << 32) / 64'd12);
      default: return 32'((64'd1 << 32) / 64'd2);
    endcase
  endfunction

  // round half up at the binary point, then saturate
  function automatic val_t qround(input logic [PROD_W-1:0] p);
    logic [PROD_W:0]             s;
    logic [PROD_W-FRAC_BITS:0]   sh;
    logic [PROD_W-VALUE_WIDTH-FRAC_BITS+1:0] hi;
    s  = {p[PROD_W-1], p} + {{(PROD_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    sh = s[PROD_W:FRAC_BITS];
    hi = sh[PROD_W-FRAC_BITS:VALUE_WIDTH-1];
    if (hi == '0 || hi == '1) return sh[VALUE_WIDTH-1:0];
    return sh[PROD_W-FRAC_BITS] ? VAL_MIN : VAL_MAX;
  endfunction

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
    return s[VALUE_WIDTH-1:0];
  endfunction

  function automatic val_t sat_neg(input val_t a);
    if (a == VAL_MIN) return VAL_MAX;
    return -a;
  endfunction

endpackage

// ----- src/mmb_front.sv -----
// front end: takes input transfers, classifies the command, holds a two-entry queue
module mmb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mmb_pkg::in_item_t item,
  output logic              work_valid,
  output mmb_pkg::work_t    work_item,
  input  logic              work_pop
);
  import mmb_pkg::*;

  work_t      entry [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       take;
  work_t      dec;

  // classify the command into operation, target and operand vector
  always_comb begin
    dec.v0  = item.vec_x;
    dec.v1  = item.vec_y;
    dec.v2  = item.vec_z;
    dec.op  = OP_NONE;
    dec.tgt = TGT_POS;
    case (cmd_e'(item.command))
      CMD_SET_POS: begin dec.op = OP_SET; dec.tgt = TGT_POS; end
      CMD_SET_ROT: begin dec.op = OP_SET; dec.tgt = TGT_ROT; end
      CMD_SET_SCL: begin dec.op = OP_SET; dec.tgt = TGT_SCL; end
      CMD_ADD_ROT: begin dec.op = OP_ADD; dec.tgt = TGT_ROT; end
      CMD_ADD_POS: begin dec.op = OP_ADD; dec.tgt = TGT_POS; end
      CMD_MUL_SCL: begin dec.op = OP_MUL; dec.tgt = TGT_SCL; end
      CMD_UNIFORM: begin
        dec.op  = OP_MUL;
        dec.tgt = TGT_SCL;
        dec.v1  = item.vec_x;
        dec.v2  = item.vec_x;
      end
      default: dec.op = OP_NONE;
    endcase
  end

  assign full       = (cnt == 2'd2);
  assign work_valid = (cnt != 2'd0);
  assign work_item  = entry[rp];
  assign take       = push && !full;

  // queue pointers and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (take) begin
        entry[wp] <= dec;
        wp        <= ~wp;
      end
      if (work_pop) rp <= ~rp;
      cnt <= cnt + 2'(take) - 2'(work_pop);
    end
  end

endmodule

// ----- src/mmb_back.sv -----
// back end: state update, sine/cosine series and matrix rows on one shared multiplier
module mmb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               work_valid,
  input  mmb_pkg::work_t     work_item,
  output logic               work_pop,
  output mmb_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);
  import mmb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_APPLY, ST_SCL, ST_LOAD, ST_RED, ST_SWAP, ST_DEG, ST_X2,
    ST_DVLD, ST_DVREC, ST_DVFIX, ST_SMUL, ST_TRIG, ST_MAT
  } state_t;

  state_t state;
  logic   ph;
  work_t  wk;

  val_t pos [3];
  val_t rot [3];
  val_t scl [3];
  val_t sn  [3];
  val_t cs  [3];
  val_t sxsy, cxsy, acc, c0, c1, c2;

  logic [1:0]       si, ai, qd;
  logic [3:0]       rk;
  logic [2:0]       di;
  logic [4:0]       mi;
  logic [RED_W-1:0] r;
  logic             swp;
  logic [Q30_W-1:0] x, x2, t, v, q0, s30;

  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] prod;

  logic      out_valid;
  out_item_t out_item;

  mop_t             mop;
  val_t             a_val, b_val, res, wb;
  val_t             wk_sel;
  logic [RED_W-1:0] rc;
  logic [36:0]      rem;
  logic [Q30_W-1:0] qfix;
  logic [Q30_W:0]   s_rnd, c_rnd;
  val_t             s_m, c_m, s_sw, c_sw, s_out, c_out;
  logic             out_free;

  function automatic val_t src_val(input src_e s);
    case (s)
      S_SX:    return sn[0];
      S_CX:    return cs[0];
      S_SY:    return sn[1];
      S_CY:    return cs[1];
      S_SZ:    return sn[2];
      S_CZ:    return cs[2];
      S_SXSY:  return sxsy;
      S_CXSY:  return cxsy;
      S_ACC:   return acc;
      S_C0:    return c0;
      S_C1:    return c1;
      S_C2:    return c2;
      S_SC0:   return scl[0];
      S_SC1:   return scl[1];
      S_SC2:   return scl[2];
      default: return ONE_Q;
    endcase
  endfunction

  function automatic val_t wk_elem(input logic [1:0] i);
    case (i)
      2'd0:    return wk.v0;
      2'd1:    return wk.v1;
      default: return wk.v2;
    endcase
  endfunction

  assign mop   = mat_op(mi);
  assign rc    = red_const(rk);
  assign res   = qround(prod);

  // matrix operands and scale operand
  always_comb a_val = src_val(mop.a);
  always_comb b_val = src_val(mop.b);
  always_comb wk_sel = wk_elem(si);

  // operand select of the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_SCL: begin
        ma = {scl[si][VALUE_WIDTH-1], scl[si]};
        mb = {wk_sel[VALUE_WIDTH-1], wk_sel};
      end
      ST_DEG:   begin ma = MUL_W'(r);  mb = DEG2RAD; end
      ST_X2:    begin ma = MUL_W'(x);  mb = MUL_W'(x); end
      ST_DVLD:  begin ma = MUL_W'(x2); mb = MUL_W'(t); end
      ST_DVREC: begin ma = MUL_W'(v);  mb = MUL_W'(div_recip(di)); end
      ST_SMUL:  begin ma = MUL_W'(x);  mb = MUL_W'(t); end
      ST_MAT: begin
        ma = {a_val[VALUE_WIDTH-1], a_val};
        mb = {b_val[VALUE_WIDTH-1], b_val};
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // combine mode of a matrix product
  always_comb begin
    case (mop.mode)
      M_NEG:   wb = sat_neg(res);
      M_ADD:   wb = sat_add(acc, res);
      M_SUB:   wb = sat_add(acc, sat_neg(res));
      default: wb = res;
    endcase
  end

  // quotient correction of the reciprocal estimate
  always_comb begin
    rem  = 37'(v) - 37'(q0) * 37'(div_den(di));
    qfix = q0 + Q30_W'(rem >= 37'(div_den(di)));
  end

  // q30 to output format, octant swap and quadrant signs
  always_comb begin
    s_rnd = {1'b0, s30} + {1'b0, Q30_HALF_LSB};
    c_rnd = {1'b0, t} + {1'b0, Q30_HALF_LSB};
    s_m   = val_t'(s_rnd[Q30_W:CONV_SH]);
    c_m   = val_t'(c_rnd[Q30_W:CONV_SH]);
    s_sw  = swp ? c_m : s_m;
    c_sw  = swp ? s_m : c_m;
    case (qd)
      2'd0:    begin s_out = s_sw;  c_out = c_sw;  end
      2'd1:    begin s_out = c_sw;  c_out = -s_sw; end
      2'd2:    begin s_out = -s_sw; c_out = -c_sw; end
      default: begin s_out = -c_sw; c_out = s_sw;  end
    endcase
  end

  assign out_free = !out_valid || pop;
  assign work_pop = (state == ST_IDLE) && work_valid;
  assign empty    = !out_valid;
  assign result   = out_item;

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state     <= ST_IDLE;
      ph        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        rot[i] <= '0;
        scl[i] <= ONE_Q;
      end
    end else begin
      if (pop && out_valid && !(state == ST_MAT && mop.kind == K_EMIT)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (work_valid) begin
            wk    <= work_item;
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          ai <= 2'd0;
          case (wk.op)
            OP_SET: begin
              state <= ST_LOAD;
              case (wk.tgt)
                TGT_POS: begin pos[0] <= wk.v0; pos[1] <= wk.v1; pos[2] <= wk.v2; end
                TGT_ROT: begin rot[0] <= wk.v0; rot[1] <= wk.v1; rot[2] <= wk.v2; end
                default: begin scl[0] <= wk.v0; scl[1] <= wk.v1; scl[2] <= wk.v2; end
              endcase
            end
            OP_ADD: begin
              state <= ST_LOAD;
              if (wk.tgt == TGT_ROT) begin
                rot[0] <= sat_add(rot[0], wk.v0);
                rot[1] <= sat_add(rot[1], wk.v1);
                rot[2] <= sat_add(rot[2], wk.v2);
              end else begin
                pos[0] <= sat_add(pos[0], wk.v0);
                pos[1] <= sat_add(pos[1], wk.v1);
                pos[2] <= sat_add(pos[2], wk.v2);
              end
            end
            OP_MUL: begin
              si    <= 2'd0;
              state <= ST_SCL;
            end
            default: state <= ST_LOAD;
          endcase
        end
        ST_SCL: begin
          ph <= ~ph;
          if (ph) begin
            scl[si] <= res;
            si      <= si + 2'd1;
            if (si == 2'd2) state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          r     <= {{(RED_W-VALUE_WIDTH){rot[ai][VALUE_WIDTH-1]}}, rot[ai]} + ANGLE_BIAS;
          rk    <= 4'd0;
          state <= ST_RED;
        end
        ST_RED: begin
          if (r >= rc) r <= r - rc;
          if (rk == 4'd8) qd[1] <= (r >= rc);
          if (rk == 4'd9) begin
            qd[0] <= (r >= rc);
            state <= ST_SWAP;
          end
          rk <= rk + 4'd1;
        end
        ST_SWAP: begin
          swp <= (r > (QUARTER_DEG >> 1));
          if (r > (QUARTER_DEG >> 1)) r <= QUARTER_DEG - r;
          state <= ST_DEG;
        end
        ST_DEG: begin
          ph <= ~ph;
          if (ph) begin
            x     <= prod[FRAC_BITS+2+Q30_W-1:FRAC_BITS+2];
            state <= ST_X2;
          end
        end
        ST_X2: begin
          ph <= ~ph;
          if (ph) begin
            x2    <= prod[30+Q30_W-1:30];
            di    <= 3'd0;
            state <= ST_DVLD;
          end
        end
        ST_DVLD: begin
          if (di == 3'd0 || di == 3'd3) begin
            v     <= x2;
            state <= ST_DVREC;
          end else begin
            ph <= ~ph;
            if (ph) begin
              v     <= prod[30+Q30_W-1:30];
              state <= ST_DVREC;
            end
          end
        end
        ST_DVREC: begin
          ph <= ~ph;
          if (ph) begin
            q0    <= prod[32+Q30_W-1:32];
            state <= ST_DVFIX;
          end
        end
        ST_DVFIX: begin
          t  <= Q30_ONE - qfix;
          di <= di + 3'd1;
          if (di == 3'd2)      state <= ST_SMUL;
          else if (di == 3'd6) state <= ST_TRIG;
          else                 state <= ST_DVLD;
        end
        ST_SMUL: begin
          ph <= ~ph;
          if (ph) begin
            s30   <= prod[30+Q30_W-1:30];
            state <= ST_DVLD;
          end
        end
        ST_TRIG: begin
          sn[ai] <= s_out;
          cs[ai] <= c_out;
          ai     <= ai + 2'd1;
          if (ai == 2'd2) begin
            mi    <= 5'd0;
            state <= ST_MAT;
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_MAT: begin
          if (mop.kind == K_EMIT) begin
            if (out_free) begin
              out_valid          <= 1'b1;
              out_item.row_index <= mop.row;
              out_item.last_row  <= (mop.row == 2'd3);
              case (mop.row)
                2'd0: begin
                  out_item.col0 <= c0; out_item.col1 <= c1;
                  out_item.col2 <= c2; out_item.col3 <= pos[0];
                end
                2'd1: begin
                  out_item.col0 <= c0; out_item.col1 <= c1;
                  out_item.col2 <= c2; out_item.col3 <= pos[1];
                end
                2'd2: begin
                  out_item.col0 <= c0; out_item.col1 <= c1;
                  out_item.col2 <= c2; out_item.col3 <= pos[2];
                end
                default: begin
                  out_item.col0 <= '0; out_item.col1 <= '0;
                  out_item.col2 <= '0; out_item.col3 <= ONE_Q;
                end
              endcase
              mi <= mi + 5'd1;
              if (mi == MAT_LAST) state <= ST_IDLE;
            end
          end else begin
            ph <= ~ph;
            if (ph) begin
              case (mop.dst)
                D_SXSY:  sxsy <= wb;
                D_CXSY:  cxsy <= wb;
                D_ACC:   acc  <= wb;
                D_C0:    c0   <= wb;
                D_C1:    c1   <= wb;
                default: c2   <= wb;
              endcase
              mi <= mi + 5'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/trs_model_matrix_builder_unit.sv -----
// top level of the model matrix builder: front queue and sequential back end
// Each input command updates position, Euler rotation (degrees) or scale and is
// answered by four row transfers of T*Rx*Ry*Rz*S, rows 0 to 3, last_row on row 3.
// From leaving the front queue to its last row, a command is worked on by the single
// shared 33x33 multiplier, which the back end walks through three sine/cosine series
// (one per angle) and 24 matrix products; stalls on the result side hold it up. The
// back end takes the next command only after the last row of the current one. The
// front queue holds two commands, so input transfers continue while one is worked on.
module trs_model_matrix_builder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mmb_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output mmb_pkg::out_item_t result
);
  import mmb_pkg::*;

  logic  work_valid;
  logic  work_pop;
  work_t work_item;

  // command intake and classification
  mmb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .work_valid (work_valid),
    .work_item  (work_item),
    .work_pop   (work_pop)
  );

  // arithmetic and row output
  mmb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work_item  (work_item),
    .work_pop   (work_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ----- src/mmb_checker.sv -----
// port-level checks of the model matrix builder and their bind
module mmb_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input mmb_pkg::out_item_t result
);
  import mmb_pkg::*;

  logic [1:0] exp_row;

  // row expected next in the result stream
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_row <= 2'd0;
    end else if (pop && !empty) begin
      exp_row <= exp_row + 2'd1;
    end
  end

  // rows come in order 0..3 for every command
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.row_index == exp_row)
    else $error("result row out of order");

  // last_row marks exactly row 3
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.last_row == (result.row_index == 2'd3))
    else $error("last_row flag mismatch");

  // bottom row is the constant 0, 0, 0, 1
  a_bottom_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.row_index == 2'd3) |->
      (result.col0 == '0 && result.col1 == '0 && result.col2 == '0 &&
       result.col3 == ONE_Q))
    else $error("bottom row not identity");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind trs_model_matrix_builder_unit mmb_checker u_mmb_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
